// ----- rtl/rtp_rob_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtp_rob_pkg
// shared constants and types of the rtp sequence reorder buffer
// ----------------------------------------------------------------------------
package rtp_rob_pkg;

   localparam int QUEUE_DEPTH = 32;
   localparam int TAG_BITS    = 12;
   localparam int SEQ_BITS    = 16;
   localparam int LIMIT_BITS  = 6;
   localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);
   localparam int CMP_BITS    = (COUNT_BITS > LIMIT_BITS) ? COUNT_BITS : LIMIT_BITS;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(32);

   typedef enum logic [1:0] {
      CMD_HOLD   = 2'b00,
      CMD_INSERT = 2'b01,
      CMD_POP    = 2'b10
   } cell_cmd_type;

   // command broadcast to every cell of the row
   typedef struct packed {
      cell_cmd_type         cmd;
      logic [SEQ_BITS-1:0]  seq;
      logic [TAG_BITS-1:0]  tag;
   } chain_ctrl_type;

   // what the row reports back to the controller
   typedef struct packed {
      logic [SEQ_BITS-1:0]  front_seq;
      logic [TAG_BITS-1:0]  front_tag;
      logic                 dup;
   } chain_status_type;

endpackage
`default_nettype wire

// ----- rtl/rtp_rob_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtp_rob_cell
// one slot of the sorted pending row: keeps, takes the new word or shifts
// ----------------------------------------------------------------------------
module rtp_rob_cell
   import rtp_rob_pkg::*;
(
   input  wire logic                 clock,
   input  wire chain_ctrl_type       ctrl,
   input  wire logic                 occupied,
   input  wire logic                 prev_lt,
   input  wire logic [SEQ_BITS-1:0]  left_seq,
   input  wire logic [TAG_BITS-1:0]  left_tag,
   input  wire logic [SEQ_BITS-1:0]  right_seq,
   input  wire logic [TAG_BITS-1:0]  right_tag,
   output logic      [SEQ_BITS-1:0]  cell_seq,
   output logic      [TAG_BITS-1:0]  cell_tag,
   output logic                      cell_lt,
   output logic                      cell_eq
);

   logic [SEQ_BITS-1:0] seq_ff, seq_in;
   logic [TAG_BITS-1:0] tag_ff, tag_in;

   always_comb begin
      cell_lt = occupied && (seq_ff < ctrl.seq);
      cell_eq = occupied && (seq_ff == ctrl.seq);
      seq_in  = seq_ff;
      tag_in  = tag_ff;
      case (ctrl.cmd)
         CMD_INSERT: begin
            if (!cell_lt) begin
               if (prev_lt) begin
                  // insertion point
                  seq_in = ctrl.seq;
                  tag_in = ctrl.tag;
               end else begin
                  seq_in = left_seq;
                  tag_in = left_tag;
               end
            end
         end
         CMD_POP: begin
            seq_in = right_seq;
            tag_in = right_tag;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      seq_ff <= seq_in;
      tag_ff <= tag_in;
   end

   assign cell_seq = seq_ff;
   assign cell_tag = tag_ff;

endmodule
`default_nettype wire

// ----- rtl/rtp_rob_chain.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtp_rob_chain
// row of cells holding the pending words in ascending sequence order
// ----------------------------------------------------------------------------
module rtp_rob_chain
   import rtp_rob_pkg::*;
(
   input  wire logic                   clock,
   input  wire chain_ctrl_type         ctrl,
   input  wire logic [COUNT_BITS-1:0]  count,
   output chain_status_type            status
);

   logic [SEQ_BITS-1:0] cell_seq [QUEUE_DEPTH];
   logic [TAG_BITS-1:0] cell_tag [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_lt;
   logic [QUEUE_DEPTH-1:0] cell_eq;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                occupied;
      logic                prev_lt;
      logic [SEQ_BITS-1:0] left_seq;
      logic [TAG_BITS-1:0] left_tag;
      logic [SEQ_BITS-1:0] right_seq;
      logic [TAG_BITS-1:0] right_tag;

      assign occupied = count > COUNT_BITS'(i);

      if (i == 0) begin : g_head
         assign prev_lt  = 1'b1;
         assign left_seq = ctrl.seq;
         assign left_tag = ctrl.tag;
      end else begin : g_body
         assign prev_lt  = cell_lt[i-1];
         assign left_seq = cell_seq[i-1];
         assign left_tag = cell_tag[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign right_seq = cell_seq[i];
         assign right_tag = cell_tag[i];
      end else begin : g_next
         assign right_seq = cell_seq[i+1];
         assign right_tag = cell_tag[i+1];
      end

      rtp_rob_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .occupied  (occupied),
         .prev_lt   (prev_lt),
         .left_seq  (left_seq),
         .left_tag  (left_tag),
         .right_seq (right_seq),
         .right_tag (right_tag),
         .cell_seq  (cell_seq[i]),
         .cell_tag  (cell_tag[i]),
         .cell_lt   (cell_lt[i]),
         .cell_eq   (cell_eq[i])
      );
   end

   assign status.front_seq = cell_seq[0];
   assign status.front_tag = cell_tag[0];
   assign status.dup       = |cell_eq;

endmodule
`default_nettype wire

// ----- rtl/rtp_sequence_reorder_buffer_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rtp_sequence_reorder_buffer_core
// reorders rtp packets by sequence number and releases them in runs
// ----------------------------------------------------------------------------
// A packet is taken when start is high and busy is low. The block then stays
// busy while it passes through ST_STEP, which releases the packet, inserts it
// into the sorted row of cells or drops it, and ST_DRAIN, which releases the
// stored words that are due and then closes the run. The next packet can be
// taken once the block is back in ST_IDLE. The drain moves the row by one cell
// per cycle, which sets the release rate at one word per clock. Each released
// word is kept in the held register until it is known whether it closes the
// run and then passes through the rsp register onto rsp_*, one per cycle with
// rsp_valid high, and the last word of a run carries rsp_run_last and shows
// in the first idle cycle.
// The receiver cannot stall: every word is shown for exactly one cycle.
// queue_limit may be written whenever the block is idle; values above the
// row depth act as the depth.
// ----------------------------------------------------------------------------
module rtp_sequence_reorder_buffer_core
   import rtp_rob_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // packet in
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [SEQ_BITS-1:0]    req_packet_seq,
   input  wire logic [TAG_BITS-1:0]    req_packet_tag,
   // released words
   output logic                        rsp_valid,
   output logic      [SEQ_BITS-1:0]    rsp_out_seq,
   output logic      [TAG_BITS-1:0]    rsp_out_tag,
   output logic                        rsp_run_last,
   // queue_limit register
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [LIMIT_BITS-1:0]  csr_queue_limit
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_STEP  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type state_ff, state_in;

   // control state
   logic                  started_ff, started_in;
   logic [SEQ_BITS-1:0]   last_seq_ff, last_seq_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [LIMIT_BITS-1:0] limit_ff;
   logic                  held_valid_ff, held_valid_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload
   logic [SEQ_BITS-1:0]   item_seq_ff, item_seq_in;
   logic [TAG_BITS-1:0]   item_tag_ff, item_tag_in;
   logic [SEQ_BITS-1:0]   held_seq_ff, held_seq_in;
   logic [TAG_BITS-1:0]   held_tag_ff, held_tag_in;
   logic [SEQ_BITS-1:0]   rsp_seq_ff, rsp_seq_in;
   logic [TAG_BITS-1:0]   rsp_tag_ff, rsp_tag_in;
   logic                  rsp_last_ff, rsp_last_in;

   chain_ctrl_type        ctrl;
   chain_status_type      status;

   logic [SEQ_BITS-1:0]   next_seq;
   logic [CMP_BITS-1:0]   limit_ext;
   logic [CMP_BITS-1:0]   limit_eff;
   logic                  at_limit;
   logic                  release_front;

   // sorted pending row
   rtp_rob_chain u_chain (
      .clock  (clock),
      .ctrl   (ctrl),
      .count  (count_ff),
      .status (status)
   );

   assign next_seq  = last_seq_ff + SEQ_BITS'(1);
   // limit clipped to the row depth, so the drain always leaves a free cell
   assign limit_ext = CMP_BITS'(limit_ff);
   assign limit_eff = (limit_ext > CMP_BITS'(QUEUE_DEPTH)) ? CMP_BITS'(QUEUE_DEPTH) : limit_ext;
   assign at_limit  = CMP_BITS'(count_ff) >= limit_eff;
   assign release_front = (count_ff != '0) && (at_limit || (status.front_seq == next_seq));

   always_comb begin
      state_in      = state_ff;
      started_in    = started_ff;
      last_seq_in   = last_seq_ff;
      count_in      = count_ff;
      held_valid_in = held_valid_ff;
      item_seq_in   = item_seq_ff;
      item_tag_in   = item_tag_ff;
      held_seq_in   = held_seq_ff;
      held_tag_in   = held_tag_ff;
      rsp_valid_in  = 1'b0;
      rsp_seq_in    = held_seq_ff;
      rsp_tag_in    = held_tag_ff;
      rsp_last_in   = 1'b0;
      ctrl.cmd      = CMD_HOLD;
      ctrl.seq      = item_seq_ff;
      ctrl.tag      = item_tag_ff;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_seq_in = req_packet_seq;
               item_tag_in = req_packet_tag;
               state_in    = ST_STEP;
            end
         end
         ST_STEP: begin
            state_in = ST_DRAIN;
            if (!started_ff || (item_seq_ff == next_seq)) begin
               // first packet or the expected one: released straight away
               started_in    = 1'b1;
               last_seq_in   = item_seq_ff;
               held_seq_in   = item_seq_ff;
               held_tag_in   = item_tag_ff;
               held_valid_in = 1'b1;
            end else if (!status.dup && (count_ff < COUNT_BITS'(QUEUE_DEPTH))) begin
               // out of order: sorted insert, duplicates dropped
               ctrl.cmd = CMD_INSERT;
               count_in = count_ff + COUNT_BITS'(1);
            end
         end
         ST_DRAIN: begin
            if (release_front) begin
               // previous word is known not to be the last of the run
               rsp_valid_in  = held_valid_ff;
               held_seq_in   = status.front_seq;
               held_tag_in   = status.front_tag;
               held_valid_in = 1'b1;
               last_seq_in   = status.front_seq;
               ctrl.cmd      = CMD_POP;
               count_in      = count_ff - COUNT_BITS'(1);
            end else begin
               rsp_valid_in  = held_valid_ff;
               rsp_last_in   = 1'b1;
               held_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         started_ff    <= 1'b0;
         last_seq_ff   <= '0;
         count_ff      <= '0;
         limit_ff      <= LIMIT_RESET;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         started_ff    <= started_in;
         last_seq_ff   <= last_seq_in;
         count_ff      <= count_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_queue_limit;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_seq_ff <= item_seq_in;
      item_tag_ff <= item_tag_in;
      held_seq_ff <= held_seq_in;
      held_tag_ff <= held_tag_in;
      rsp_seq_ff  <= rsp_seq_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign csr_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_seq  = rsp_seq_ff;
   assign rsp_out_tag  = rsp_tag_ff;
   assign rsp_run_last = rsp_last_ff;

`ifndef SYNTH
   // fill count never runs past the row depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(QUEUE_DEPTH))
      else $error("pending count beyond depth");

   // no word is left held once the block is idle
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !held_valid_ff)
      else $error("held word left behind");

   // a run's last word is followed by a gap
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |=> !rsp_valid_ff)
      else $error("word right after end of run");

   // each pop takes exactly one word off the row
   assert property (@(posedge clock) disable iff (reset)
      (ctrl.cmd == CMD_POP) |=> (count_ff == $past(count_ff) - COUNT_BITS'(1)))
      else $error("pop did not shrink the row");
`endif

endmodule
`default_nettype wire
